[design/dbd_pkg.sv]
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared widths, month table and constants for the day-distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dbd_pkg;

    localparam int unsigned DAY_W  = 5;
    localparam int unsigned MON_W  = 4;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned DIST_W = 22;

    // Default for the top-level year ceiling
    localparam int unsigned MAX_YEAR_DEF = 9999;

    // Request packing on the stream buses
    localparam int unsigned IN_FIELDS_W = 2 * (DAY_W + MON_W + YEAR_W);
    localparam int unsigned IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_W  = ((DIST_W + 7) / 8) * 8;

    localparam logic [MON_W-1:0] MONTH_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MONTH_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MONTH_DEC = MON_W'(12);

    // Year quotient by 100: floor(x * 5243 / 2^19), exact for 14-bit x
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;
    localparam int unsigned DIV100_PW    = YEAR_W + 13;
    localparam int unsigned Q100_W       = $clog2((2 ** YEAR_W) / 100 + 1);
    localparam int unsigned CENT_W       = 7;
    localparam logic [CENT_W-1:0] CENT_LAST = CENT_W'(99);

    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned MOFF_W        = 9;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Days before the first of each month, common year; entry 0 unused
    localparam logic [MOFF_W-1:0] MONTH_START [13] = '{
        MOFF_W'(0),   MOFF_W'(0),   MOFF_W'(31),  MOFF_W'(59),  MOFF_W'(90),
        MOFF_W'(120), MOFF_W'(151), MOFF_W'(181), MOFF_W'(212), MOFF_W'(243),
        MOFF_W'(273), MOFF_W'(304), MOFF_W'(334)
    };

endpackage

`default_nettype wire

[design/days_between_dates_top.sv]
// ----------------------------------------------------------------------------
// days_between_dates_top
// Absolute day distance between two Gregorian dates, five-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake                     | Contents
//  ---------+-----+-------------------------------+---------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | two dates (day, month, year)
//  m_axis   | out | m_axis_tvalid / m_axis_tready | day distance
//
//  One request per cycle while m_axis_tready is high.
//  Depth is set by the year/100 reciprocal multiply and the day-number adds.
//  Each stage holds while the stage after it is full and stalled, so a full
//  pipe still takes a request whenever the result is being taken.
//  rst_n clears the stage valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module days_between_dates_top #(
    parameter int unsigned MAX_YEAR = dbd_pkg::MAX_YEAR_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // low to high: first_day, first_month, first_year,
    //              second_day, second_month, second_year, zero pad
    input  wire  [dbd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // low to high: day_distance, zero pad
    output logic [dbd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    import dbd_pkg::*;

    localparam int unsigned NSTG     = 5;
    localparam int unsigned YEAR_TOP = (MAX_YEAR < (2 ** YEAR_W) - 1) ?
                                       MAX_YEAR : (2 ** YEAR_W) - 1;
    localparam int unsigned DN_W     = $clog2(YEAR_TOP * 366 + 1);
    localparam int unsigned CMP_W    = (DN_W > DIST_W) ? DN_W : DIST_W;

    typedef struct packed {
        logic [YEAR_W-1:0] py;
        logic              feb_past;
        logic [MOFF_W-1:0] mon_off;
        logic [DAY_W-1:0]  day;
    } st1_t;

    typedef struct packed {
        logic [YEAR_W-1:0] py;
        logic [Q100_W-1:0] q100;
        logic              feb_past;
        logic [MOFF_W-1:0] mon_off;
        logic [DAY_W-1:0]  day;
    } st2_t;

    typedef struct packed {
        logic [DN_W-1:0]   yd;
        logic [Q100_W-1:0] cent;
        logic              leap_add;
        logic [MOFF_W-1:0] mon_off;
        logic [DAY_W-1:0]  day;
    } st3_t;

    logic [NSTG-1:0]   vld_reg;
    logic [NSTG-1:0]   rdy;

    st1_t              st1_reg  [2];
    st1_t              st1_next [2];
    st2_t              st2_reg  [2];
    st2_t              st2_next [2];
    st3_t              st3_reg  [2];
    st3_t              st3_next [2];
    logic [DN_W-1:0]   dn_reg   [2];
    logic [DN_W-1:0]   dn_next  [2];
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;

    logic [DAY_W-1:0]  in_day  [2];
    logic [MON_W-1:0]  in_mon  [2];
    logic [YEAR_W-1:0] in_year [2];

    // Input unpacking
    assign in_day[0]  = s_axis_tdata[DAY_W-1:0];
    assign in_mon[0]  = s_axis_tdata[DAY_W+MON_W-1:DAY_W];
    assign in_year[0] = s_axis_tdata[DAY_W+MON_W+YEAR_W-1:DAY_W+MON_W];
    assign in_day[1]  = s_axis_tdata[2*DAY_W+MON_W+YEAR_W-1:DAY_W+MON_W+YEAR_W];
    assign in_mon[1]  = s_axis_tdata[2*DAY_W+2*MON_W+YEAR_W-1:2*DAY_W+MON_W+YEAR_W];
    assign in_year[1] = s_axis_tdata[IN_FIELDS_W-1:2*DAY_W+2*MON_W+YEAR_W];

    // Stage handshake: a stage loads when empty or when its contents move on
    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: clamp month and year, month offset from table
    always_comb
    begin
        logic [MON_W-1:0]  mon;
        logic [YEAR_W-1:0] yr;
        for (int i = 0; i < 2; i++)
        begin
            mon = in_mon[i];
            if (mon < MONTH_JAN)
            begin
                mon = MONTH_JAN;
            end
            else if (mon > MONTH_DEC)
            begin
                mon = MONTH_DEC;
            end
            yr = in_year[i];
            if (yr == '0)
            begin
                yr = YEAR_W'(1);
            end
            else if (32'(yr) > MAX_YEAR)
            begin
                yr = YEAR_W'(YEAR_TOP);
            end
            st1_next[i].py       = yr - YEAR_W'(1);
            st1_next[i].feb_past = (mon > MONTH_FEB);
            st1_next[i].mon_off  = MONTH_START[mon];
            st1_next[i].day      = in_day[i];
        end
    end

    // Stage 2: whole centuries of elapsed years by reciprocal multiply
    always_comb
    begin
        logic [DIV100_PW-1:0] prod;
        for (int i = 0; i < 2; i++)
        begin
            prod = DIV100_PW'(st1_reg[i].py) * DIV100_PW'(DIV100_MUL);
            st2_next[i].py       = st1_reg[i].py;
            st2_next[i].q100     = Q100_W'(prod >> DIV100_SHIFT);
            st2_next[i].feb_past = st1_reg[i].feb_past;
            st2_next[i].mon_off  = st1_reg[i].mon_off;
            st2_next[i].day      = st1_reg[i].day;
        end
    end

    // Stage 3: leap test on the date's own year, days of elapsed years
    always_comb
    begin
        logic [YEAR_W-1:0] rem_w;
        logic [CENT_W-1:0] r100;
        logic              leap;
        for (int i = 0; i < 2; i++)
        begin
            rem_w = st2_reg[i].py - YEAR_W'(YEAR_W'(st2_reg[i].q100) * YEAR_W'(100));
            r100  = rem_w[CENT_W-1:0];
            // year = py + 1: divisible by 4 when py ends in 3 mod 4, etc.
            leap  = ((st2_reg[i].py[1:0] == 2'b11) && (r100 != CENT_LAST)) ||
                    ((r100 == CENT_LAST) && (st2_reg[i].q100[1:0] == 2'b11));
            st3_next[i].yd       = DN_W'(st2_reg[i].py) * DN_W'(DAYS_PER_YEAR)
                                 + DN_W'(st2_reg[i].py >> 2);
            st3_next[i].cent     = st2_reg[i].q100 - (st2_reg[i].q100 >> 2);
            st3_next[i].leap_add = leap && st2_reg[i].feb_past;
            st3_next[i].mon_off  = st2_reg[i].mon_off;
            st3_next[i].day      = st2_reg[i].day;
        end
    end

    // Stage 4: day number from year 1
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            dn_next[i] = st3_reg[i].yd - DN_W'(st3_reg[i].cent)
                       + DN_W'(st3_reg[i].mon_off)
                       + DN_W'(st3_reg[i].leap_add)
                       + DN_W'(st3_reg[i].day);
        end
    end

    // Stage 5: absolute difference, saturated to the output width
    always_comb
    begin
        logic [CMP_W-1:0] diff;
        if (dn_reg[0] > dn_reg[1])
        begin
            diff = CMP_W'(dn_reg[0] - dn_reg[1]);
        end
        else
        begin
            diff = CMP_W'(dn_reg[1] - dn_reg[0]);
        end
        if (diff > CMP_W'(DIST_MAX))
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = DIST_W'(diff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && s_axis_tvalid)
        begin
            st1_reg <= st1_next;
        end
        if (rdy[1] && vld_reg[0])
        begin
            st2_reg <= st2_next;
        end
        if (rdy[2] && vld_reg[1])
        begin
            st3_reg <= st3_next;
        end
        if (rdy[3] && vld_reg[2])
        begin
            dn_reg <= dn_next;
        end
        if (rdy[4] && vld_reg[3])
        begin
            dist_reg <= dist_next;
        end
    end

    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = OUT_DATA_W'(dist_reg);

    // A full stage whose successor cannot take it keeps its request
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[2] && !rdy[3]) |=> vld_reg[2])
        else $error("stage 3 request lost under stall");

    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[1] && !rdy[2]) |=> (vld_reg[1] && $stable(st2_reg[0].py)))
        else $error("stage 2 request changed under stall");

    // Input is only taken when the pipe has room somewhere
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!(&vld_reg) || m_axis_tready))
        else $error("request accepted into a full stalled pipe");

    // An advancing stage 4 request appears at the output next cycle
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && rdy[4]) |=> m_axis_tvalid)
        else $error("result dropped between last two stages");

endmodule

`default_nettype wire
